// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DRR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DRR_ASSERT(lbl, prop, msg) `DRR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define DRR_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define DRR_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- sv/drr_pkg.sv -----
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types and constants of the dielectric scatter core.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam int unsigned RI_W   = 15;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned PNT_W  = 32;
  localparam int unsigned RND_W  = 16;
  localparam int unsigned RSQ_W  = 30;
  localparam int unsigned R0_W   = 16;
  localparam int unsigned ETAF_W = 29;
  localparam int unsigned ETAB_W = 19;
  localparam int unsigned QUO_W  = 30;  // quotient bits of the per-word divider
  localparam int unsigned SQRT_W = 15;  // root bits
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned BACK_STAGES  = 3;
  localparam int unsigned DIV_PER_STAGE  = 3;
  localparam int unsigned SQRT_PER_STAGE = 3;

  // config-side serial divider
  localparam int unsigned CDIV_W     = 48;
  localparam int unsigned CDIV_ITERS = 48;
  localparam int unsigned CCNT_W     = 6;

  localparam longint unsigned RI_RST   = 64'd6144;
  localparam longint unsigned R0_RST   =
    (((RI_RST - 64'd4096) * (RI_RST - 64'd4096)) << 16) /
    ((RI_RST + 64'd4096) * (RI_RST + 64'd4096));
  localparam longint unsigned ETAF_RST = (64'd1 << 28) / RI_RST;
  localparam longint unsigned RSQ_RST  = RI_RST * RI_RST;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_SQUARE,
    CFG_DIV_R0,
    CFG_DIV_ETA
  } cfg_state_e;

  typedef struct packed {
    logic [RSQ_W-1:0]  rsq;
    logic [R0_W-1:0]   r0;
    logic [ETAF_W-1:0] eta_f;
    logic [ETAB_W-1:0] eta_b;
  } cfg_t;

  typedef struct packed {
    logic [2:0][15:0] d;
    logic [2:0][15:0] n;
    logic [2:0][31:0] hit;
    logic             front;
    logic [15:0]      rnd;
    logic [2:0][31:0] prod;
    logic [33:0]      dot;
    logic [15:0]      c;
    logic [15:0]      p;
    logic [28:0]      csq;
    logic [16:0]      p2;
    logic [2:0][23:0] refo;
    logic [28:0]      sin2;
    logic [18:0]      p4;
    logic [28:0]      eta;
    logic [29:0]      etac;
    logic [58:0]      bigp;
    logic             tirf;
    logic [19:0]      p5;
    logic [2:0][29:0] ed;
    logic             tir;
    logic [36:0]      reflprod;
    logic [34:0]      termb;
    logic             reflect;
    logic [30:0]      rem;
    logic [29:0]      quo;
    logic [28:0]      v;
    logic [29:0]      root;
    logic [30:0]      coef;
    logic [2:0][32:0] cn;
    logic [2:0][15:0] o;
  } item_t;

endpackage

// ----- sv/drr_cfg.sv -----
// ----------------------------------------------------------------------------
// drr_cfg
// Index register and its derived terms; r0 and 1/R come from a bit-serial divider.
// ----------------------------------------------------------------------------
module drr_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [drr_pkg::RI_W-1:0] cfg_wdata_i,
  output drr_pkg::cfg_t            cfg_o,
  output logic                     busy_o
);
  import drr_pkg::*;

  cfg_state_e          state_q, state_d;
  logic [RI_W-1:0]     rie_q, rie_d;
  logic [RSQ_W-1:0]    rsq_q, rsq_d;
  logic [R0_W-1:0]     r0_q, r0_d;
  logic [ETAF_W-1:0]   etaf_q, etaf_d;
  logic [CCNT_W-1:0]   cnt_q, cnt_d;
  logic [CDIV_W-1:0]   dvd_q, dvd_d;
  logic [31:0]         dsr_q, dsr_d;
  logic [31:0]         rem_q, rem_d;
  logic [31:0]         rem_sh;
  logic                ge;
  logic [CDIV_W-1:0]   dvd_step;
  logic [31:0]         rem_step;
  logic [RI_W-1:0]     num;
  logic [RI_W:0]       den;
  logic                last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_IDLE;
      cnt_q   <= '0;
      rie_q   <= RI_W'(RI_RST);
      rsq_q   <= RSQ_W'(RSQ_RST);
      r0_q    <= R0_W'(R0_RST);
      etaf_q  <= ETAF_W'(ETAF_RST);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rie_q   <= rie_d;
      rsq_q   <= rsq_d;
      r0_q    <= r0_d;
      etaf_q  <= etaf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem_q[30:0], dvd_q[CDIV_W-1]};
    ge       = rem_sh >= dsr_q;
    rem_step = ge ? rem_sh - dsr_q : rem_sh;
    dvd_step = {dvd_q[CDIV_W-2:0], ge};
    last     = cnt_q == CCNT_W'(CDIV_ITERS - 1);
    num      = (rie_q > RI_W'(4096)) ? rie_q - RI_W'(4096) : RI_W'(4096) - rie_q;
    den      = (RI_W+1)'(rie_q) + (RI_W+1)'(4096);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rie_d   = rie_q;
    rsq_d   = rsq_q;
    r0_d    = r0_q;
    etaf_d  = etaf_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    case (state_q)
      CFG_IDLE: ;
      CFG_SQUARE: begin
        rsq_d   = RSQ_W'(32'(rie_q) * 32'(rie_q));
        dvd_d   = CDIV_W'({32'(num) * 32'(num), 16'd0});
        dsr_d   = 32'(den) * 32'(den);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = CFG_DIV_R0;
      end
      CFG_DIV_R0: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        cnt_d = cnt_q + CCNT_W'(1);
        if (last) begin
          r0_d    = dvd_step[R0_W-1:0];
          dvd_d   = CDIV_W'(1) << 28;
          dsr_d   = 32'(rie_q);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = CFG_DIV_ETA;
        end
      end
      CFG_DIV_ETA: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        cnt_d = cnt_q + CCNT_W'(1);
        if (last) begin
          etaf_d  = dvd_step[ETAF_W-1:0];
          state_d = CFG_IDLE;
        end
      end
      default: state_d = CFG_IDLE;
    endcase
    if (cfg_we_i) begin
      // zero index reads as the smallest step
      rie_d   = (cfg_wdata_i == '0) ? RI_W'(1) : cfg_wdata_i;
      state_d = CFG_SQUARE;
    end
  end

  assign cfg_o.rsq   = rsq_q;
  assign cfg_o.r0    = r0_q;
  assign cfg_o.eta_f = etaf_q;
  assign cfg_o.eta_b = {rie_q, 4'd0};
  assign busy_o      = state_q != CFG_IDLE;

endmodule

// ----- sv/drr_front.sv -----
// ----------------------------------------------------------------------------
// drr_front
// Dot product, cosine, Schlick terms, reflection test, divider setup.
// ----------------------------------------------------------------------------
module drr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  drr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drr_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drr_pkg::item_t out_item_o
);
  import drr_pkg::*;

  localparam int unsigned N = FRONT_STAGES;

  item_t        st_q [N];
  item_t        src  [N];
  item_t        nx   [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] src_vld;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
    src[0]     = in_item_i;
    src_vld[0] = in_valid_i;
    for (int k = 1; k < N; k++) begin
      src[k]     = st_q[k-1];
      src_vld[k] = vld_q[k-1];
    end
  end

  always_comb begin
    logic signed [33:0] dot_s;
    logic signed [33:0] negdot_s;
    logic signed [33:0] cs_s;
    logic signed [16:0] p_s;
    logic signed [49:0] dn_s;
    logic signed [45:0] ec_s;
    logic [16:0]        one_m_r0;
    logic [23:0]        refl;
    for (int k = 0; k < N; k++) begin
      dot_s    = '0;
      negdot_s = '0;
      cs_s     = '0;
      p_s      = '0;
      dn_s     = '0;
      ec_s     = '0;
      one_m_r0 = '0;
      refl     = '0;
      nx[k]    = src[k];
      case (k)
        0: begin
          for (int i = 0; i < 3; i++)
            nx[k].prod[i] = 32'($signed(src[k].d[i]) * $signed(src[k].n[i]));
        end
        1: begin
          dot_s = 34'($signed(src[k].prod[0])) + 34'($signed(src[k].prod[1]))
                + 34'($signed(src[k].prod[2]));
          nx[k].dot = dot_s;
          negdot_s  = -dot_s;
          cs_s      = negdot_s >>> 14;
          if (cs_s > 34'sd16384)       nx[k].c = 16'd16384;
          else if (cs_s < -34'sd16384) nx[k].c = 16'hC000;
          else                         nx[k].c = cs_s[15:0];
          p_s     = 17'sd16384 - 17'($signed(nx[k].c));
          nx[k].p = p_s[15:0];
        end
        2: begin
          nx[k].csq = 29'($signed(src[k].c) * $signed(src[k].c));
          nx[k].p2  = 17'((32'(src[k].p) * 32'(src[k].p)) >> 14);
          for (int i = 0; i < 3; i++) begin
            dn_s = 50'($signed(src[k].dot) * $signed(src[k].n[i]));
            nx[k].refo[i] = 24'($signed(src[k].d[i])) - 24'(dn_s >>> 27);
          end
        end
        3: begin
          nx[k].sin2 = 29'(30'd268435456 - 30'(src[k].csq));
          nx[k].p4   = 19'((34'(src[k].p2) * 34'(src[k].p2)) >> 14);
          nx[k].eta  = src[k].front ? cfg_i.eta_f : ETAF_W'(cfg_i.eta_b);
          ec_s       = 46'($signed({1'b0, nx[k].eta}) * $signed(src[k].c));
          nx[k].etac = 30'(ec_s >>> 16);
        end
        4: begin
          nx[k].bigp = 59'(59'(cfg_i.rsq) * 59'(src[k].sin2));
          nx[k].tirf = 34'(src[k].sin2) > {cfg_i.rsq, 4'd0};
          nx[k].p5   = 20'((35'(src[k].p4) * 35'(src[k].p)) >> 14);
          for (int i = 0; i < 3; i++) begin
            ec_s = 46'($signed({1'b0, src[k].eta}) * $signed(src[k].d[i]));
            nx[k].ed[i] = 30'(ec_s >>> 16);
          end
        end
        5: begin
          // back face: total internal reflection when R^2*sin2 > 2^52
          nx[k].tir      = src[k].front ? src[k].tirf : (src[k].bigp > (59'(1) << 52));
          one_m_r0       = 17'd65536 - 17'(cfg_i.r0);
          nx[k].reflprod = 37'(37'(one_m_r0) * 37'(src[k].p5));
          nx[k].termb    = src[k].bigp[58:24];
        end
        6: begin
          refl          = 24'(cfg_i.r0) + 24'(src[k].reflprod >> 14);
          nx[k].reflect = src[k].tir || (refl > 24'(src[k].rnd));
          // quotient fits QUO_W bits whenever it is used
          nx[k].rem     = 31'(src[k].sin2[28:6]);
          nx[k].quo     = {src[k].sin2[5:0], 24'd0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) if (rdy[k]) vld_q[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) if (rdy[k]) st_q[k] <= nx[k];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_item_o  = st_q[N-1];

endmodule

// ----- sv/drr_div.sv -----
// ----------------------------------------------------------------------------
// drr_div
// Pipelined restoring divider: sin2 * 2^24 / R^2 for the front face.
// ----------------------------------------------------------------------------
module drr_div #(
  parameter int unsigned PerStage = drr_pkg::DIV_PER_STAGE
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [drr_pkg::RSQ_W-1:0] rsq_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  drr_pkg::item_t            in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output drr_pkg::item_t            out_item_o
);
  import drr_pkg::*;

  localparam int unsigned N = (QUO_W + PerStage - 1) / PerStage;

  item_t        st_q [N];
  item_t        src  [N];
  item_t        nx   [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] src_vld;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
    src[0]     = in_item_i;
    src_vld[0] = in_valid_i;
    for (int k = 1; k < N; k++) begin
      src[k]     = st_q[k-1];
      src_vld[k] = vld_q[k-1];
    end
  end

  always_comb begin
    item_t       w;
    logic [30:0] rem_sh;
    for (int k = 0; k < N; k++) begin
      w      = src[k];
      rem_sh = '0;
      for (int t = 0; t < PerStage; t++) begin
        if (k * PerStage + t < QUO_W) begin
          rem_sh = {w.rem[29:0], w.quo[QUO_W-1]};
          w.quo  = {w.quo[QUO_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, rsq_i}) begin
            w.rem    = rem_sh - {1'b0, rsq_i};
            w.quo[0] = 1'b1;
          end else begin
            w.rem = rem_sh;
          end
        end
      end
      nx[k] = w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) if (rdy[k]) vld_q[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) if (rdy[k]) st_q[k] <= nx[k];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_item_o  = st_q[N-1];

endmodule

// ----- sv/drr_sqrt.sv -----
// ----------------------------------------------------------------------------
// drr_sqrt
// Radicand select and pipelined digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module drr_sqrt #(
  parameter int unsigned PerStage = drr_pkg::SQRT_PER_STAGE
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drr_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drr_pkg::item_t out_item_o
);
  import drr_pkg::*;

  localparam int unsigned N = 1 + (SQRT_W + PerStage - 1) / PerStage;

  item_t        st_q [N];
  item_t        src  [N];
  item_t        nx   [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] src_vld;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
    src[0]     = in_item_i;
    src_vld[0] = in_valid_i;
    for (int k = 1; k < N; k++) begin
      src[k]     = st_q[k-1];
      src_vld[k] = vld_q[k-1];
    end
  end

  always_comb begin
    item_t       w;
    logic [34:0] term;
    logic [29:0] bitv;
    logic [29:0] trial;
    for (int k = 0; k < N; k++) begin
      w     = src[k];
      term  = '0;
      bitv  = '0;
      trial = '0;
      if (k == 0) begin
        // k = max(1 - eta^2 sin^2, 0) in Q28
        term   = w.front ? 35'(w.quo) : w.termb;
        w.v    = (term > 35'd268435456) ? 29'd0 : 29'(35'd268435456 - term);
        w.root = '0;
      end else begin
        for (int t = 0; t < PerStage; t++) begin
          if ((k - 1) * PerStage + t < SQRT_W) begin
            bitv  = 30'(1) << (2 * (SQRT_W - 1 - ((k - 1) * PerStage + t)));
            trial = w.root + bitv;
            if (30'(w.v) >= trial) begin
              w.v    = 29'(30'(w.v) - trial);
              w.root = (w.root >> 1) + bitv;
            end else begin
              w.root = w.root >> 1;
            end
          end
        end
      end
      nx[k] = w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) if (rdy[k]) vld_q[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) if (rdy[k]) st_q[k] <= nx[k];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_item_o  = st_q[N-1];

endmodule

// ----- sv/drr_back.sv -----
// ----------------------------------------------------------------------------
// drr_back
// Refracted direction, reflect/refract select, saturation, output register.
// ----------------------------------------------------------------------------
module drr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drr_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drr_pkg::item_t out_item_o
);
  import drr_pkg::*;

  localparam int unsigned N = BACK_STAGES;

  item_t        st_q [N];
  item_t        src  [N];
  item_t        nx   [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] src_vld;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
    src[0]     = in_item_i;
    src_vld[0] = in_valid_i;
    for (int k = 1; k < N; k++) begin
      src[k]     = st_q[k-1];
      src_vld[k] = vld_q[k-1];
    end
  end

  always_comb begin
    logic signed [46:0] cm;
    logic signed [34:0] val;
    for (int k = 0; k < N; k++) begin
      cm    = '0;
      val   = '0;
      nx[k] = src[k];
      case (k)
        0: nx[k].coef = 31'($signed(src[k].etac)) - 31'(src[k].root[SQRT_W-1:0]);
        1: begin
          for (int i = 0; i < 3; i++) begin
            cm = 47'($signed(src[k].coef) * $signed(src[k].n[i]));
            nx[k].cn[i] = 33'(cm >>> 14);
          end
        end
        2: begin
          for (int i = 0; i < 3; i++) begin
            if (src[k].reflect) val = 35'($signed(src[k].refo[i]));
            else val = 35'($signed(src[k].ed[i])) + 35'($signed(src[k].cn[i]));
            if (val > 35'sd32767)       nx[k].o[i] = 16'h7FFF;
            else if (val < -35'sd32768) nx[k].o[i] = 16'h8000;
            else                        nx[k].o[i] = val[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) if (rdy[k]) vld_q[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) if (rdy[k]) st_q[k] <= nx[k];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_item_o  = st_q[N-1];

endmodule

// ----- sv/dielectric_refract_or_reflect_core.sv -----
// ----------------------------------------------------------------------------
// dielectric_refract_or_reflect_core
// Dielectric scatter with Schlick Fresnel: one ray hit word in, one scattered
// ray word out. Words stream at one per cycle unless an output stall backs up
// to the input or an index rebuild holds it. Words pass the front stages, the
// front-face quotient divider, the square root pipeline and the back stages in
// that order. Every stage has its own valid bit and moves on whenever the
// stage after it is empty or moving, so bubbles are squeezed out and a stall
// at the output backs up stage by stage without losing or repeating a word.
// The output stage is a register. After a write to the index register the
// block holds in_stall_o high while r0 and 1/R are rebuilt by a bit-serial
// divider; write the register only with the pipeline empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dielectric_refract_or_reflect_core #(
  parameter int unsigned DivPerStage  = drr_pkg::DIV_PER_STAGE,
  parameter int unsigned SqrtPerStage = drr_pkg::SQRT_PER_STAGE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // index register, unsigned Q3.12
  input  logic                     cfg_we_i,
  input  logic [drr_pkg::RI_W-1:0] cfg_wdata_i,
  // hit word
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [15:0]       dir_x_i,
  input  logic signed [15:0]       dir_y_i,
  input  logic signed [15:0]       dir_z_i,
  input  logic signed [15:0]       normal_x_i,
  input  logic signed [15:0]       normal_y_i,
  input  logic signed [15:0]       normal_z_i,
  input  logic                     front_face_i,
  input  logic [15:0]              random_word_i,
  input  logic signed [31:0]       hit_x_i,
  input  logic signed [31:0]       hit_y_i,
  input  logic signed [31:0]       hit_z_i,
  // scattered ray word
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       out_dir_x_o,
  output logic signed [15:0]       out_dir_y_o,
  output logic signed [15:0]       out_dir_z_o,
  output logic signed [31:0]       origin_x_o,
  output logic signed [31:0]       origin_y_o,
  output logic signed [31:0]       origin_z_o,
  output logic                     was_reflected_o
);
  import drr_pkg::*;

  cfg_t  cfg;
  logic  cfg_busy;
  item_t in_item;
  item_t f2d_item, d2s_item, s2b_item, out_item;
  logic  f_in_valid, f_in_ready;
  logic  f2d_valid, f2d_ready;
  logic  d2s_valid, d2s_ready;
  logic  s2b_valid, s2b_ready;

  drr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .busy_o      (cfg_busy)
  );

  // pack the hit word; the rest of the fields fill in down the pipe
  always_comb begin
    in_item        = '0;
    in_item.d[0]   = dir_x_i;
    in_item.d[1]   = dir_y_i;
    in_item.d[2]   = dir_z_i;
    in_item.n[0]   = normal_x_i;
    in_item.n[1]   = normal_y_i;
    in_item.n[2]   = normal_z_i;
    in_item.hit[0] = hit_x_i;
    in_item.hit[1] = hit_y_i;
    in_item.hit[2] = hit_z_i;
    in_item.front  = front_face_i;
    in_item.rnd    = random_word_i;
  end

  // no word enters while the derived index terms are being rebuilt
  assign f_in_valid = in_valid_i && !cfg_busy && !cfg_we_i;
  assign in_stall_o = cfg_busy || cfg_we_i || !f_in_ready;

  drr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (f_in_valid),
    .in_ready_o  (f_in_ready),
    .in_item_i   (in_item),
    .out_valid_o (f2d_valid),
    .out_ready_i (f2d_ready),
    .out_item_o  (f2d_item)
  );

  drr_div #(
    .PerStage (DivPerStage)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsq_i       (cfg.rsq),
    .in_valid_i  (f2d_valid),
    .in_ready_o  (f2d_ready),
    .in_item_i   (f2d_item),
    .out_valid_o (d2s_valid),
    .out_ready_i (d2s_ready),
    .out_item_o  (d2s_item)
  );

  drr_sqrt #(
    .PerStage (SqrtPerStage)
  ) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d2s_valid),
    .in_ready_o  (d2s_ready),
    .in_item_i   (d2s_item),
    .out_valid_o (s2b_valid),
    .out_ready_i (s2b_ready),
    .out_item_o  (s2b_item)
  );

  drr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2b_valid),
    .in_ready_o  (s2b_ready),
    .in_item_i   (s2b_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_item_o  (out_item)
  );

  assign out_dir_x_o     = out_item.o[0];
  assign out_dir_y_o     = out_item.o[1];
  assign out_dir_z_o     = out_item.o[2];
  assign origin_x_o      = out_item.hit[0];
  assign origin_y_o      = out_item.hit[1];
  assign origin_z_o      = out_item.hit[2];
  assign was_reflected_o = out_item.reflect;

  // a write always starts a rebuild of the derived terms
  `DRR_ASSERT(a_write_starts_rebuild, cfg_we_i |=> cfg_busy, "index write did not start rebuild")
  // words must not enter while derived terms are stale
  `DRR_ASSERT(a_rebuild_holds_input, cfg_busy |-> in_stall_o, "input open during rebuild")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Dielectric scatter core testbench
// Streams ray hit words through the core under random valid/stall idling,
// predicts every scattered ray word in a scoreboard and compares each field.
// Several index settings are used, including zero and both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // one ray hit word
  typedef struct {
    logic signed [15:0] dir [3];
    logic signed [15:0] nrm [3];
    logic               front;
    logic [15:0]        rnd;
    logic signed [31:0] hit [3];
  } hit_word_t;

  // one scattered ray word
  typedef struct {
    logic signed [15:0] dir [3];
    logic signed [31:0] org [3];
    logic               refl;
  } ray_word_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the index, queue of predicted rays
  // --------------------------------------------------------------------------
  class ray_scoreboard;
    logic [drr_pkg::RI_W-1:0] index_q;
    ray_word_t                pending_rays[$];

    function new();
      index_q = 15'd6144;
    endfunction

    static function longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    static function logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function ray_word_t scatter(hit_word_t h);
      ray_word_t r;
      longint d[3], n[3], dot, c, sin2, ri, rsq, num, den, r0;
      longint p, p2, p4, p5, refl, term, k, s, eta, coef;
      bit tir;
      ri = (index_q == 0) ? 64'sd1 : longint'(index_q);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(h.dir[i]);
        n[i] = longint'(h.nrm[i]);
        dot += d[i] * n[i];
      end
      c = (-dot) >>> 14;
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      sin2 = (64'sd1 <<< 28) - c * c;
      rsq = ri * ri;
      tir = h.front ? (sin2 > rsq * 16) : (rsq * sin2 > (64'sd1 <<< 52));
      num = (ri > 4096) ? ri - 4096 : 4096 - ri;
      den = ri + 4096;
      r0 = ((num * num) <<< 16) / (den * den);
      p = 16384 - c;
      p2 = (p * p) >>> 14;
      p4 = (p2 * p2) >>> 14;
      p5 = (p4 * p) >>> 14;
      refl = r0 + (((65536 - r0) * p5) >>> 14);
      r.refl = tir || (refl > longint'(h.rnd));
      if (r.refl) begin
        for (int i = 0; i < 3; i++) r.dir[i] = clip16(d[i] - ((dot * n[i]) >>> 27));
      end else begin
        term = h.front ? ((sin2 <<< 24) / rsq) : ((rsq * sin2) >>> 24);
        k = (64'sd1 <<< 28) - term;
        if (k < 0) k = 0;
        s = int_sqrt(k);
        eta = h.front ? ((64'sd1 <<< 28) / ri) : ri * 16;
        coef = ((eta * c) >>> 16) - s;
        for (int i = 0; i < 3; i++)
          r.dir[i] = clip16(((eta * d[i]) >>> 16) + ((coef * n[i]) >>> 14));
      end
      for (int i = 0; i < 3; i++) r.org[i] = h.hit[i];
      return r;
    endfunction

    function void note_hit(hit_word_t h);
      pending_rays.push_back(scatter(h));
    endfunction

    // returns an empty string on a match, else a description
    function string check_ray(ray_word_t got);
      ray_word_t e;
      string msg;
      if (pending_rays.size() == 0) return "ray word with no prediction pending";
      e = pending_rays.pop_front();
      msg = "";
      for (int i = 0; i < 3; i++) begin
        if (got.dir[i] !== e.dir[i])
          msg = {msg, $sformatf(" dir[%0d] %0d/%0d", i, got.dir[i], e.dir[i])};
        if (got.org[i] !== e.org[i])
          msg = {msg, $sformatf(" org[%0d] %0d/%0d", i, got.org[i], e.org[i])};
      end
      if (got.refl !== e.refl)
        msg = {msg, $sformatf(" refl %0b/%0b", got.refl, e.refl)};
      return msg;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [drr_pkg::RI_W-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [15:0]       dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [15:0]       normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic                     front_face_i = 1'b0;
  logic [15:0]              random_word_i = '0;
  logic signed [31:0]       hit_x_i = '0, hit_y_i = '0, hit_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [15:0]       out_dir_x_o, out_dir_y_o, out_dir_z_o;
  logic signed [31:0]       origin_x_o, origin_y_o, origin_z_o;
  logic                     was_reflected_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dielectric_refract_or_reflect_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .front_face_i   (front_face_i),
    .random_word_i  (random_word_i),
    .hit_x_i        (hit_x_i),
    .hit_y_i        (hit_y_i),
    .hit_z_i        (hit_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_dir_x_o    (out_dir_x_o),
    .out_dir_y_o    (out_dir_y_o),
    .out_dir_z_o    (out_dir_z_o),
    .origin_x_o     (origin_x_o),
    .origin_y_o     (origin_y_o),
    .origin_z_o     (origin_z_o),
    .was_reflected_o(was_reflected_o)
  );

  ray_scoreboard sb = new();
  int  fail_count = 0;
  bit  quiet_mode = 1'b0;   // no idling on either side
  bit  hold_out   = 1'b0;   // long receiver hold-off request
  int  idle_cycles = 0;

  task automatic report(string msg);
    $display("MISMATCH @%0t:%s", $realtime, msg);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // monitors: sample at the edge, before the core's own updates land
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hit_word_t h;
    ray_word_t r;
    string     msg;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      h.dir[0] = dir_x_i;  h.dir[1] = dir_y_i;  h.dir[2] = dir_z_i;
      h.nrm[0] = normal_x_i; h.nrm[1] = normal_y_i; h.nrm[2] = normal_z_i;
      h.front = front_face_i;
      h.rnd = random_word_i;
      h.hit[0] = hit_x_i;  h.hit[1] = hit_y_i;  h.hit[2] = hit_z_i;
      sb.note_hit(h);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.dir[0] = out_dir_x_o; r.dir[1] = out_dir_y_o; r.dir[2] = out_dir_z_o;
      r.org[0] = origin_x_o;  r.org[1] = origin_y_o;  r.org[2] = origin_z_o;
      r.refl = was_reflected_o;
      msg = sb.check_ray(r);
      if (msg != "") report(msg);
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("dielectric_refract_or_reflect_core test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  task automatic send_hit(hit_word_t h);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    dir_x_i       <= h.dir[0];
    dir_y_i       <= h.dir[1];
    dir_z_i       <= h.dir[2];
    normal_x_i    <= h.nrm[0];
    normal_y_i    <= h.nrm[1];
    normal_z_i    <= h.nrm[2];
    front_face_i  <= h.front;
    random_word_i <= h.rnd;
    hit_x_i       <= h.hit[0];
    hit_y_i       <= h.hit[1];
    hit_z_i       <= h.hit[2];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_rays.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // only with the pipeline empty; the core stalls its input while rebuilding
  task automatic write_index(logic [drr_pkg::RI_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.index_q = val;
  endtask

  function automatic hit_word_t make_hit(int d0, int d1, int d2, int n0, int n1, int n2,
                                         bit f, int rnd);
    hit_word_t h;
    h.dir[0] = 16'(d0); h.dir[1] = 16'(d1); h.dir[2] = 16'(d2);
    h.nrm[0] = 16'(n0); h.nrm[1] = 16'(n1); h.nrm[2] = 16'(n2);
    h.front = f;
    h.rnd = 16'(rnd);
    for (int i = 0; i < 3; i++) h.hit[i] = $urandom;
    return h;
  endfunction

  // random unit ray and facing normal; a few raw-bit noise words
  function automatic hit_word_t random_hit();
    hit_word_t h;
    real dv[3], nv[3], dl, nl, dp;
    h = make_hit(0, 0, 0, 0, 0, 0, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 3; i++) begin
        h.dir[i] = 16'($urandom);
        h.nrm[i] = 16'($urandom);
      end
      return h;
    end
    dl = 0.0; nl = 0.0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = $urandom_range(0, 20000) / 10000.0 - 1.0;
      nv[i] = $urandom_range(0, 20000) / 10000.0 - 1.0;
      dl += dv[i] * dv[i];
      nl += nv[i] * nv[i];
    end
    dl = $sqrt(dl) + 1.0e-9;
    nl = $sqrt(nl) + 1.0e-9;
    dp = 0.0;
    for (int i = 0; i < 3; i++) dp += dv[i] * nv[i];
    for (int i = 0; i < 3; i++) begin
      if (dp > 0.0) nv[i] = -nv[i];  // normal faces the ray
      h.dir[i] = 16'($rtoi(dv[i] / dl * 16384.0));
      h.nrm[i] = 16'($rtoi(nv[i] / nl * 16384.0));
    end
    return h;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [drr_pkg::RI_W-1:0] settings[7];
    hit_word_t h;
    settings = '{15'd6144, 15'd0, 15'd4096, 15'd32767, 15'd5461, 15'd0, 15'd6144};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: head-on, grazing, reversed, zero, overflow, extreme words
    send_hit(make_hit(16384, 0, 0, -16384, 0, 0, 1, 0));
    send_hit(make_hit(16384, 0, 0, -16384, 0, 0, 0, 65535));
    send_hit(make_hit(0, 16384, 0, 0, 0, -16384, 0, 65535));   // grazing, back face
    send_hit(make_hit(0, 16384, 0, 0, 0, -16384, 1, 65535));
    send_hit(make_hit(0, 0, -16384, 0, 0, -16384, 1, 0));      // cos at its lower bound, -1
    send_hit(make_hit(0, 0, 0, 0, 0, 0, 0, 0));
    send_hit(make_hit(-32768, -32768, -32768, -32768, -32768, -32768, 1, 65535));
    send_hit(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    send_hit(make_hit(32767, -32768, 32767, -32768, 32767, -32768, 0, 65535));
    send_hit(make_hit(11585, 11585, 0, 0, -16384, 0, 0, 30000));
    send_hit(make_hit(11585, -11585, 0, -11585, 11585, 0, 1, 1));
    h = make_hit(9459, 9459, -9459, -16384, 0, 0, 0, 65535);
    h.hit = '{32'sh7fffffff, 32'sh80000000, 32'sh0};
    send_hit(h);
    h.hit = '{32'sh80000000, 32'sh7fffffff, -32'sd1};
    h.front = 1'b1;
    send_hit(h);
    drain();

    // random phases, one index setting each
    foreach (settings[ph]) begin
      write_index(ph == 4 ? 15'($urandom_range(4096, 32767)) : settings[ph]);
      for (int i = 0; i < 185; i++) begin
        if (ph == 2 && i == 20) hold_out = 1'b1;     // fill the pipeline
        if (ph == 3 && i == 90) drain();             // sender waits for all rays
        if (ph == 6) quiet_mode = 1'b1;
        send_hit(random_hit());
      end
      drain();
    end

    if (fail_count == 0)
      $display("dielectric_refract_or_reflect_core test passed");
    else
      $display("dielectric_refract_or_reflect_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/drr_pkg.sv
sv/drr_cfg.sv
sv/drr_front.sv
sv/drr_div.sv
sv/drr_sqrt.sv
sv/drr_back.sv
sv/dielectric_refract_or_reflect_core.sv
verif/testbench.sv
